FILE: sv/cpd_pkg.sv
// Package: shared types, codes and helpers for the color pair dibit stream decoder.
package cpd_pkg;

  localparam int PairsPerColumnDef = 8;
  localparam int ColumnsDef        = 4;
  localparam int LinesDef          = 40;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  localparam logic [7:0] WhiteThresholdRst = 8'd180;
  localparam logic [7:0] BlackThresholdRst = 8'd30;
  localparam logic [7:0] HueMarginRst      = 8'd10;

  localparam logic [1:0] RegWhiteThreshold = 2'd0;
  localparam logic [1:0] RegBlackThreshold = 2'd1;
  localparam logic [1:0] RegHueMargin      = 2'd2;

  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  localparam logic [1:0] StatusBlack   = 2'd0;
  localparam logic [1:0] StatusAbsent  = 2'd1;
  localparam logic [1:0] StatusPresent = 2'd2;

  typedef enum logic [2:0] {
    ColorBlack = 3'd0,
    ColorRed   = 3'd1,
    ColorGreen = 3'd2,
    ColorBlue  = 3'd3,
    ColorWhite = 3'd4
  } color_e;

  typedef enum logic [1:0] {
    PhaseClock = 2'd0,
    PhaseData  = 2'd1,
    PhaseIdle  = 2'd2
  } phase_e;

  // one classified sample travelling from front to back
  typedef struct packed {
    logic   frame_start;
    color_e color;
  } sample_t;

  function automatic logic [31:0] byte_swap(input logic [31:0] w);
    byte_swap = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

FILE: sv/cpd_front.sv
// Front end: configuration registers and per-sample color classification.
module cpd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [7:0]       cfg_data_i,
  input  logic             frame_start_i,
  input  logic [7:0]       first_red_i,
  input  logic [7:0]       first_green_i,
  input  logic [7:0]       first_blue_i,
  input  logic [7:0]       second_red_i,
  input  logic [7:0]       second_green_i,
  input  logic [7:0]       second_blue_i,
  output cpd_pkg::sample_t sample_o
);

  logic [7:0] white_q, black_q, margin_q;
  logic [7:0] avg_r, avg_g, avg_b;
  logic [9:0] chan_sum;
  logic [9:0] white_lim, black_lim;
  logic [8:0] red_lim, green_lim, blue_lim;
  cpd_pkg::color_e color;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_q  <= cpd_pkg::WhiteThresholdRst;
      black_q  <= cpd_pkg::BlackThresholdRst;
      margin_q <= cpd_pkg::HueMarginRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cpd_pkg::RegWhiteThreshold: white_q  <= cfg_data_i;
        cpd_pkg::RegBlackThreshold: black_q  <= cfg_data_i;
        cpd_pkg::RegHueMargin:      margin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    avg_r = 8'((9'(first_red_i)   + 9'(second_red_i))   >> 1);
    avg_g = 8'((9'(first_green_i) + 9'(second_green_i)) >> 1);
    avg_b = 8'((9'(first_blue_i)  + 9'(second_blue_i))  >> 1);
    chan_sum = 10'(avg_r) + 10'(avg_g) + 10'(avg_b);
    // luma = sum/3: compare the sum against scaled thresholds instead
    white_lim = 10'(white_q) * 10'd3 + 10'd2;
    black_lim = 10'(black_q) * 10'd3;
    red_lim   = 9'(8'((9'(avg_b) + 9'(avg_g)) >> 1)) + 9'(margin_q);
    green_lim = 9'(8'((9'(avg_b) + 9'(avg_r)) >> 1)) + 9'(margin_q);
    blue_lim  = 9'(8'((9'(avg_r) + 9'(avg_g)) >> 1)) + 9'(margin_q);
    if (chan_sum > white_lim) begin
      color = cpd_pkg::ColorWhite;
    end else if (chan_sum < black_lim) begin
      color = cpd_pkg::ColorBlack;
    end else if (9'(avg_r) > red_lim) begin
      color = cpd_pkg::ColorRed;
    end else if (9'(avg_g) > green_lim) begin
      color = cpd_pkg::ColorGreen;
    end else if (9'(avg_b) > blue_lim) begin
      color = cpd_pkg::ColorBlue;
    end else begin
      color = cpd_pkg::ColorBlack;
    end
    sample_o.frame_start = frame_start_i;
    sample_o.color       = color;
  end

endmodule

FILE: sv/cpd_queue.sv
// Short request queue between the classifier and the decoder back end.
module cpd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cpd_pkg::sample_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output cpd_pkg::sample_t pop_data_o
);

  cpd_pkg::sample_t mem_q [cpd_pkg::QueueDepth];
  logic [cpd_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [cpd_pkg::QueuePtrW:0]   count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  assign full_o     = (count_q == (cpd_pkg::QueuePtrW + 1)'(cpd_pkg::QueueDepth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

endmodule

FILE: sv/cpd_back.sv
// Back end: pairing, clock line check, dibit decode, line interleave and result register.
module cpd_back #(
  parameter int PairsPerColumn = cpd_pkg::PairsPerColumnDef,
  parameter int Columns        = cpd_pkg::ColumnsDef,
  parameter int Lines          = cpd_pkg::LinesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  cpd_pkg::sample_t q_data_i,
  output logic             q_pop_o,
  output logic             result_valid_o,
  input  logic             result_stall_i,
  output logic             result_kind_o,
  output logic [31:0]      data_word_o,
  output logic [1:0]       frame_status_o,
  output logic [6:0]       word_index_o
);

  localparam int PcW  = (PairsPerColumn > 1) ? $clog2(PairsPerColumn) : 1;
  localparam int ColW = (Columns > 1) ? $clog2(Columns) : 1;
  localparam int LnW  = $clog2(Lines);

  cpd_pkg::phase_e phase_q, phase_d;
  logic            sip_q, sip_d;
  cpd_pkg::color_e held_q, held_d;
  logic [PcW-1:0]  pc_q, pc_d;
  logic [ColW-1:0] col_q, col_d;
  logic [LnW-1:0]  line_q, line_d;
  logic [1:0]      last_q, last_d;
  logic [31:0]     shift_q, shift_d;
  logic            empty_q, empty_d;
  logic            ok_q, ok_d;
  logic [31:0]     even_q [Columns];

  logic            out_ready;
  logic            emit;
  logic            emit_kind;
  logic [31:0]     emit_word;
  logic [1:0]      emit_status;
  logic [6:0]      emit_index;
  logic            even_we;
  logic [31:0]     even_wdata;

  logic            out_valid_q, out_valid_d;
  logic            out_kind_q;
  logic [31:0]     out_word_q;
  logic [1:0]      out_status_q;
  logic [6:0]      out_index_q;

  assign out_ready = !out_valid_q || !result_stall_i;
  assign q_pop_o   = q_valid_i && out_ready;

  always_comb begin
    cpd_pkg::phase_e ph;
    cpd_pkg::color_e a, b;
    logic [1:0]  dibit;
    logic [31:0] sw;
    logic [1:0]  st;
    logic [15:0] idx;

    phase_d     = phase_q;
    sip_d       = sip_q;
    held_d      = held_q;
    pc_d        = pc_q;
    col_d       = col_q;
    line_d      = line_q;
    last_d      = last_q;
    shift_d     = shift_q;
    empty_d     = empty_q;
    ok_d        = ok_q;
    emit        = 1'b0;
    emit_kind   = cpd_pkg::KindData;
    emit_word   = '0;
    emit_status = cpd_pkg::StatusBlack;
    emit_index  = '0;
    even_we     = 1'b0;
    even_wdata  = '0;
    ph          = phase_q;
    a           = held_q;
    b           = q_data_i.color;
    dibit       = last_q;
    sw          = '0;
    st          = cpd_pkg::StatusBlack;
    idx         = '0;

    if (q_pop_o) begin
      if (q_data_i.frame_start) begin
        ph      = cpd_pkg::PhaseClock;
        phase_d = cpd_pkg::PhaseClock;
        sip_d   = 1'b0;
        pc_d    = '0;
        col_d   = '0;
        line_d  = '0;
        empty_d = 1'b1;
        ok_d    = 1'b1;
      end
      if (ph == cpd_pkg::PhaseClock || ph == cpd_pkg::PhaseData) begin
        if (!sip_d) begin
          held_d = q_data_i.color;
          sip_d  = 1'b1;
        end else begin
          sip_d = 1'b0;
          if (ph == cpd_pkg::PhaseClock) begin
            if (b != cpd_pkg::ColorBlack) empty_d = 1'b0;
            if (a != cpd_pkg::ColorBlue && b != cpd_pkg::ColorRed) ok_d = 1'b0;
            if (pc_d == PcW'(PairsPerColumn - 1)) begin
              pc_d = '0;
              if (empty_d) st = cpd_pkg::StatusBlack;
              else if (ok_d) st = cpd_pkg::StatusPresent;
              else st = cpd_pkg::StatusAbsent;
              phase_d     = (st == cpd_pkg::StatusPresent) ? cpd_pkg::PhaseData
                                                           : cpd_pkg::PhaseIdle;
              col_d       = '0;
              line_d      = '0;
              shift_d     = '0;
              emit        = 1'b1;
              emit_kind   = cpd_pkg::KindStatus;
              emit_status = st;
            end else begin
              pc_d = pc_d + 1'b1;
            end
          end else begin
            if (a == cpd_pkg::ColorBlack && b == cpd_pkg::ColorWhite) dibit = 2'd0;
            else if (a == cpd_pkg::ColorBlue && b == cpd_pkg::ColorRed) dibit = 2'd3;
            else if (a == cpd_pkg::ColorRed && b == cpd_pkg::ColorGreen) dibit = 2'd1;
            else if (a == cpd_pkg::ColorGreen && b == cpd_pkg::ColorBlue) dibit = 2'd2;
            else dibit = last_q;
            last_d = dibit;
            sw = (pc_d == '0) ? 32'd0 : shift_q;
            sw = {dibit, 2'b00, sw[31:4]};
            if (pc_d == PcW'(PairsPerColumn - 1)) begin
              pc_d    = '0;
              even_we = 1'b1;
              if (line_d[0]) begin
                even_wdata = even_q[col_d] | sw;
                idx        = 16'(line_d >> 1) * 16'(Columns) + 16'(col_d);
                emit       = 1'b1;
                emit_kind  = cpd_pkg::KindData;
                emit_word  = cpd_pkg::byte_swap(even_wdata);
                emit_index = idx[6:0];
              end else begin
                even_wdata = sw >> 2;
              end
              shift_d = '0;
              if (col_d == ColW'(Columns - 1)) begin
                col_d = '0;
                if (line_d == LnW'(Lines - 1)) begin
                  line_d  = '0;
                  phase_d = cpd_pkg::PhaseIdle;
                end else begin
                  line_d = line_d + 1'b1;
                end
              end else begin
                col_d = col_d + 1'b1;
              end
            end else begin
              shift_d = sw;
              pc_d    = pc_d + 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && result_stall_i;
    if (emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= cpd_pkg::PhaseClock;
      sip_q       <= 1'b0;
      held_q      <= cpd_pkg::ColorBlack;
      pc_q        <= '0;
      col_q       <= '0;
      line_q      <= '0;
      last_q      <= '0;
      shift_q     <= '0;
      empty_q     <= 1'b1;
      ok_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      sip_q       <= sip_d;
      held_q      <= held_d;
      pc_q        <= pc_d;
      col_q       <= col_d;
      line_q      <= line_d;
      last_q      <= last_d;
      shift_q     <= shift_d;
      empty_q     <= empty_d;
      ok_q        <= ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  // even-line words: a column's entry is always written before it is read
  always_ff @(posedge clk_i) begin
    if (even_we) even_q[col_q] <= even_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q   <= emit_kind;
      out_word_q   <= emit_word;
      out_status_q <= emit_status;
      out_index_q  <= emit_index;
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_kind_o  = out_kind_q;
  assign data_word_o    = out_word_q;
  assign frame_status_o = out_status_q;
  assign word_index_o   = out_index_q;

endmodule

FILE: sv/color_pair_dibit_stream_decoder_unit.sv
// Top level of the color pair dibit stream decoder.
// Configuration writes take effect on the next sample. A sample is classified
// in the cycle it is accepted and queued. While no output stall holds the
// result register, the back end retires one queued sample per clock and the
// block sustains one sample per cycle; a result (frame status or data word)
// is registered as its last sample leaves the queue. Input stall rises only
// when the four-entry queue is full, which happens only under an output stall.
module color_pair_dibit_stream_decoder_unit #(
  parameter int PairsPerColumn = cpd_pkg::PairsPerColumnDef,
  parameter int Columns        = cpd_pkg::ColumnsDef,
  parameter int Lines          = cpd_pkg::LinesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        sample_valid_i,
  output logic        sample_stall_o,
  input  logic        frame_start_i,
  input  logic [7:0]  first_red_i,
  input  logic [7:0]  first_green_i,
  input  logic [7:0]  first_blue_i,
  input  logic [7:0]  second_red_i,
  input  logic [7:0]  second_green_i,
  input  logic [7:0]  second_blue_i,
  output logic        result_valid_o,
  input  logic        result_stall_i,
  output logic        result_kind_o,
  output logic [31:0] data_word_o,
  output logic [1:0]  frame_status_o,
  output logic [6:0]  word_index_o
);

  cpd_pkg::sample_t front_sample, q_sample;
  logic q_full, q_valid, q_pop, push;

  assign sample_stall_o = q_full;
  assign push           = sample_valid_i && !q_full;

  cpd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .frame_start_i (frame_start_i),
    .first_red_i   (first_red_i),
    .first_green_i (first_green_i),
    .first_blue_i  (first_blue_i),
    .second_red_i  (second_red_i),
    .second_green_i(second_green_i),
    .second_blue_i (second_blue_i),
    .sample_o      (front_sample)
  );

  cpd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(front_sample),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_sample)
  );

  cpd_back #(
    .PairsPerColumn(PairsPerColumn),
    .Columns       (Columns),
    .Lines         (Lines)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_sample),
    .q_pop_o       (q_pop),
    .result_valid_o(result_valid_o),
    .result_stall_i(result_stall_i),
    .result_kind_o (result_kind_o),
    .data_word_o   (data_word_o),
    .frame_status_o(frame_status_o),
    .word_index_o  (word_index_o)
  );

endmodule

FILE: sv/cpd_checker.sv
// Port-level checker for the color pair dibit stream decoder, bound to the top level.
module cpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        result_valid_o,
  input logic        result_stall_i,
  input logic        result_kind_o,
  input logic [31:0] data_word_o,
  input logic [1:0]  frame_status_o,
  input logic [6:0]  word_index_o
);

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_stall_i |=> result_valid_o)
    else $error("result request dropped while stalled");

  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_stall_i |=>
      $stable(result_kind_o) && $stable(data_word_o) &&
      $stable(frame_status_o) && $stable(word_index_o))
    else $error("result payload changed while stalled");

  a_status_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_kind_o == cpd_pkg::KindStatus) |->
      (data_word_o == 32'd0) && (word_index_o == 7'd0) &&
      (frame_status_o != 2'd3))
    else $error("status result carries data fields");

  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_kind_o == cpd_pkg::KindData) |->
      (frame_status_o == cpd_pkg::StatusBlack))
    else $error("data result carries a frame status");

endmodule

bind color_pair_dibit_stream_decoder_unit cpd_checker u_cpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .result_valid_o(result_valid_o),
  .result_stall_i(result_stall_i),
  .result_kind_o (result_kind_o),
  .data_word_o   (data_word_o),
  .frame_status_o(frame_status_o),
  .word_index_o  (word_index_o)
);

FILE: dv/color_pair_dibit_stream_decoder_unit_tb.sv
// Testbench for the color pair dibit stream decoder: random frames checked against a predictor.
`timescale 1ns / 100ps

module color_pair_dibit_stream_decoder_unit_tb;

  localparam int Pairs = cpd_pkg::PairsPerColumnDef;
  localparam int Cols  = cpd_pkg::ColumnsDef;
  localparam int Lines = cpd_pkg::LinesDef;
  localparam int unsigned CycleLimit = 500_000;

  localparam int unsigned FrameGood   = 0;
  localparam int unsigned FrameBlack  = 1;
  localparam int unsigned FrameBroken = 2;

  localparam logic [47:0] Dark   = 48'h0;
  localparam logic [47:0] Bright = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] r1, g1, b1, r2, g2, b2;
  } pixel_req_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] word;
    logic [1:0]  status;
    logic [6:0]  index;
  } decode_result_t;

  typedef struct packed {
    logic        fs;
    logic [47:0] rgb;
    logic        typed;
    logic [1:0]  status;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = cpd_pkg::RegWhiteThreshold;
  logic [7:0]  cfg_data_i = 8'h0;
  logic        sample_valid_i = 1'b0;
  logic        sample_stall_o;
  logic        frame_start_i = 1'b0;
  logic [7:0]  first_red_i = 8'h0;
  logic [7:0]  first_green_i = 8'h0;
  logic [7:0]  first_blue_i = 8'h0;
  logic [7:0]  second_red_i = 8'h0;
  logic [7:0]  second_green_i = 8'h0;
  logic [7:0]  second_blue_i = 8'h0;
  logic        result_valid_o;
  logic        result_stall_i = 1'b0;
  logic        result_kind_o;
  logic [31:0] data_word_o;
  logic [1:0]  frame_status_o;
  logic [6:0]  word_index_o;

  color_pair_dibit_stream_decoder_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [7:0]      thr_white = cpd_pkg::WhiteThresholdRst;
  logic [7:0]      thr_black = cpd_pkg::BlackThresholdRst;
  logic [7:0]      margin    = cpd_pkg::HueMarginRst;
  cpd_pkg::phase_e dec_phase = cpd_pkg::PhaseClock;
  bit              dec_half = 1'b0;
  cpd_pkg::color_e dec_first = cpd_pkg::ColorBlack;
  int unsigned     dec_pairs = 0;
  int unsigned     dec_col = 0;
  int unsigned     dec_line = 0;
  logic [1:0]      dec_dibit = 2'd0;
  logic [31:0]     dec_shift = 32'h0;
  logic [31:0]     dec_even [Cols];
  bit              dec_empty = 1'b1;
  bit              dec_clk_ok = 1'b1;

  decode_result_t pending_results [$];
  int unsigned    live_items = 0;
  int unsigned    mismatches = 0;
  int unsigned    cycle_count = 0;
  bit             calm = 1'b0;
  logic           hold_on = 1'b0;
  int unsigned    rx_wait = 0;
  int unsigned    rx_draw;
  decode_result_t mon_got, mon_want;
  int unsigned    phase_budget [5] = '{300, 150, 150, 175, 175};

  dir_row_t dir_table [33] = '{
    {1'b1, Dark,   1'b0, cpd_pkg::StatusBlack},
    {1'b0, Bright, 1'b0, cpd_pkg::StatusBlack},
    {1'b0, Dark,   1'b0, cpd_pkg::StatusBlack},
    {1'b0, Bright, 1'b0, cpd_pkg::StatusBlack},
    {1'b0, Dark,   1'b0, cpd_pkg::StatusBlack},
    {1'b0, Bright, 1'b0, cpd_pkg::StatusBlack},
    {1'b0, Dark,   1'b0, cpd_pkg::StatusBlack},
    {1'b0, Bright, 1'b0, cpd_pkg::StatusBlack},
    {1'b0, Dark,   1'b0, cpd_pkg::StatusBlack},
    {1'b0, Bright, 1'b0, cpd_pkg::StatusBlack},
    {1'b0, Dark,   1'b0, cpd_pkg::StatusBlack},
    {1'b0, Bright, 1'b0, cpd_pkg::StatusBlack},
    {1'b0, Dark,   1'b0, cpd_pkg::StatusBlack},
    {1'b0, Bright, 1'b0, cpd_pkg::StatusBlack},
    {1'b0, Dark,   1'b0, cpd_pkg::StatusBlack},
    {1'b0, Bright, 1'b1, cpd_pkg::StatusAbsent},
    {1'b0, Bright, 1'b0, cpd_pkg::StatusBlack},
    {1'b1, Bright, 1'b0, cpd_pkg::StatusBlack},
    {1'b0, Dark,   1'b0, cpd_pkg::StatusBlack},
    {1'b0, Bright, 1'b0, cpd_pkg::StatusBlack},
    {1'b0, Dark,   1'b0, cpd_pkg::StatusBlack},
    {1'b0, Bright, 1'b0, cpd_pkg::StatusBlack},
    {1'b0, Dark,   1'b0, cpd_pkg::StatusBlack},
    {1'b0, Bright, 1'b0, cpd_pkg::StatusBlack},
    {1'b0, Dark,   1'b0, cpd_pkg::StatusBlack},
    {1'b0, Bright, 1'b0, cpd_pkg::StatusBlack},
    {1'b0, Dark,   1'b0, cpd_pkg::StatusBlack},
    {1'b0, Bright, 1'b0, cpd_pkg::StatusBlack},
    {1'b0, Dark,   1'b0, cpd_pkg::StatusBlack},
    {1'b0, Bright, 1'b0, cpd_pkg::StatusBlack},
    {1'b0, Dark,   1'b0, cpd_pkg::StatusBlack},
    {1'b0, Bright, 1'b0, cpd_pkg::StatusBlack},
    {1'b0, Dark,   1'b1, cpd_pkg::StatusBlack}
  };

  initial begin
    foreach (dec_even[i]) dec_even[i] = 32'h0;
  end

  function automatic cpd_pkg::color_e classify_sample(input pixel_req_t req);
    int unsigned r, g, b, lum;
    r = (int'(req.r1) + int'(req.r2)) / 2;
    g = (int'(req.g1) + int'(req.g2)) / 2;
    b = (int'(req.b1) + int'(req.b2)) / 2;
    lum = (r + g + b) / 3;
    if (lum > thr_white) return cpd_pkg::ColorWhite;
    if (lum < thr_black) return cpd_pkg::ColorBlack;
    if (r > (b + g) / 2 + margin) return cpd_pkg::ColorRed;
    if (g > (b + r) / 2 + margin) return cpd_pkg::ColorGreen;
    if (b > (r + g) / 2 + margin) return cpd_pkg::ColorBlue;
    return cpd_pkg::ColorBlack;
  endfunction

  function automatic bit decode_step(input pixel_req_t req, output decode_result_t res);
    cpd_pkg::color_e a, c;
    logic [1:0]      d;
    int unsigned     col;
    logic [31:0]     w;
    bit              emitted;
    res = '0;
    emitted = 1'b0;
    if (req.frame_start) begin
      dec_phase = cpd_pkg::PhaseClock;
      dec_half = 1'b0;
      dec_pairs = 0;
      dec_col = 0;
      dec_line = 0;
      dec_empty = 1'b1;
      dec_clk_ok = 1'b1;
    end
    if (dec_phase != cpd_pkg::PhaseClock && dec_phase != cpd_pkg::PhaseData) return 1'b0;
    c = classify_sample(req);
    if (!dec_half) begin
      dec_first = c;
      dec_half = 1'b1;
      return 1'b0;
    end
    dec_half = 1'b0;
    a = dec_first;
    if (dec_phase == cpd_pkg::PhaseClock) begin
      if (c != cpd_pkg::ColorBlack) dec_empty = 1'b0;
      if (a != cpd_pkg::ColorBlue && c != cpd_pkg::ColorRed) dec_clk_ok = 1'b0;
      dec_pairs++;
      if (dec_pairs < Pairs) return 1'b0;
      dec_pairs = 0;
      res.kind = cpd_pkg::KindStatus;
      res.status = dec_empty ? cpd_pkg::StatusBlack
                 : (dec_clk_ok ? cpd_pkg::StatusPresent : cpd_pkg::StatusAbsent);
      dec_phase = (res.status == cpd_pkg::StatusPresent) ? cpd_pkg::PhaseData
                                                         : cpd_pkg::PhaseIdle;
      dec_col = 0;
      dec_line = 0;
      dec_shift = 32'h0;
      return 1'b1;
    end
    if (a == cpd_pkg::ColorBlack && c == cpd_pkg::ColorWhite) d = 2'd0;
    else if (a == cpd_pkg::ColorBlue && c == cpd_pkg::ColorRed) d = 2'd3;
    else if (a == cpd_pkg::ColorRed && c == cpd_pkg::ColorGreen) d = 2'd1;
    else if (a == cpd_pkg::ColorGreen && c == cpd_pkg::ColorBlue) d = 2'd2;
    else d = dec_dibit;
    dec_dibit = d;
    if (dec_pairs == 0) dec_shift = 32'h0;
    dec_shift = (dec_shift >> 4) | {d, 30'b0};
    dec_pairs++;
    if (dec_pairs < Pairs) return 1'b0;
    dec_pairs = 0;
    col = dec_col % Cols;
    if (dec_line % 2 == 1) begin
      w = dec_even[col] | dec_shift;
      dec_even[col] = w;
      res.kind = cpd_pkg::KindData;
      res.word = {w[7:0], w[15:8], w[23:16], w[31:24]};
      res.index = 7'((dec_line / 2) * Cols + col);
      emitted = 1'b1;
    end else begin
      dec_even[col] = dec_shift >> 2;
    end
    dec_shift = 32'h0;
    dec_col++;
    if (dec_col >= Cols) begin
      dec_col = 0;
      dec_line++;
      if (dec_line >= Lines) begin
        dec_line = 0;
        dec_phase = cpd_pkg::PhaseIdle;
      end
    end
    return emitted;
  endfunction

  function automatic cpd_pkg::color_e rand_color();
    return cpd_pkg::color_e'(3'($urandom_range(0, 4)));
  endfunction

  function automatic logic [23:0] pick_pixel(input cpd_pkg::color_e c);
    logic [7:0] lo0, lo1, hi;
    lo0 = 8'($urandom_range(0, 60));
    lo1 = 8'($urandom_range(0, 60));
    hi  = 8'($urandom_range(150, 255));
    case (c)
      cpd_pkg::ColorRed:   return {hi, lo0, lo1};
      cpd_pkg::ColorGreen: return {lo0, hi, lo1};
      cpd_pkg::ColorBlue:  return {lo0, lo1, hi};
      cpd_pkg::ColorWhite: return {8'($urandom_range(200, 255)), 8'($urandom_range(200, 255)),
                                   8'($urandom_range(200, 255))};
      default:             return {8'($urandom_range(0, 25)), 8'($urandom_range(0, 25)),
                                   8'($urandom_range(0, 25))};
    endcase
  endfunction

  function automatic pixel_req_t make_req(input cpd_pkg::color_e c, input logic fs);
    return {fs, pick_pixel(c), pick_pixel(c)};
  endfunction

  function automatic pixel_req_t raw_req();
    return {1'b0, 32'($urandom), 16'($urandom)};
  endfunction

  // offer one request; predict once the block takes it
  task automatic offer(input pixel_req_t req, input bit typed, input decode_result_t want);
    int unsigned    gap;
    decode_result_t res;
    bit             made;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      sample_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    {frame_start_i, first_red_i, first_green_i, first_blue_i,
     second_red_i, second_green_i, second_blue_i} <= req;
    do @(posedge clk_i); while (sample_stall_o);
    if (req.frame_start || dec_phase != cpd_pkg::PhaseIdle) live_items++;
    made = decode_step(req, res);
    if (typed) pending_results.push_back(want);
    else if (made) pending_results.push_back(res);
  endtask

  task automatic send_pair(input cpd_pkg::color_e a, input cpd_pkg::color_e b, input logic fs);
    offer(make_req(a, fs), 1'b0, '0);
    offer(make_req(b, 1'b0), 1'b0, '0);
  endtask

  task automatic run_frame(input int unsigned style, input int unsigned data_pairs);
    cpd_pkg::color_e a, b;
    int unsigned     p;
    for (p = 0; p < Pairs; p++) begin
      case (style)
        FrameGood: begin
          a = cpd_pkg::ColorBlue;
          b = cpd_pkg::ColorRed;
        end
        FrameBlack: begin
          a = rand_color();
          b = cpd_pkg::ColorBlack;
        end
        default: begin
          a = rand_color();
          b = rand_color();
        end
      endcase
      send_pair(a, b, p == 0);
    end
    for (p = 0; p < data_pairs; p++) begin
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 3))
          0: begin a = cpd_pkg::ColorBlack; b = cpd_pkg::ColorWhite; end
          1: begin a = cpd_pkg::ColorRed;   b = cpd_pkg::ColorGreen; end
          2: begin a = cpd_pkg::ColorGreen; b = cpd_pkg::ColorBlue;  end
          default: begin a = cpd_pkg::ColorBlue; b = cpd_pkg::ColorRed; end
        endcase
        send_pair(a, b, 1'b0);
      end else if ($urandom_range(0, 1) == 0) begin
        send_pair(rand_color(), rand_color(), 1'b0);
      end else begin
        offer(raw_req(), 1'b0, '0);
        offer(raw_req(), 1'b0, '0);
      end
    end
    // dangling half pair, or ignored samples once idle
    if ($urandom_range(0, 3) == 0) offer(raw_req(), 1'b0, '0);
  endtask

  task automatic settle();
    sample_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] w, input logic [7:0] b, input logic [7:0] h);
    cfg_we_i <= 1'b1;
    cfg_index_i <= cpd_pkg::RegWhiteThreshold;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_index_i <= cpd_pkg::RegBlackThreshold;
    cfg_data_i <= b;
    @(posedge clk_i);
    cfg_index_i <= cpd_pkg::RegHueMargin;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    thr_white = w;
    thr_black = b;
    margin = h;
  endtask

  // receiver: per-result stall draw, plus one long hold to back up the block
  always @(posedge clk_i) begin
    if (hold_on) begin
      result_stall_i <= 1'b1;
    end else if (result_valid_o && !result_stall_i) begin
      rx_draw = calm ? 0 : $urandom_range(0, 7);
      rx_wait <= rx_draw;
      result_stall_i <= (rx_draw != 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      result_stall_i <= (rx_wait > 1);
    end else begin
      result_stall_i <= !calm && ($urandom_range(0, 7) == 0);
    end
  end

  initial begin
    wait (live_items >= 150);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o && !result_stall_i) begin
      mon_got = {result_kind_o, data_word_o, frame_status_o, word_index_o};
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: kind %0d word %h status %0d index %0d",
                   mon_got.kind, mon_got.word, mon_got.status, mon_got.index);
        mismatches++;
      end else begin
        mon_want = pending_results.pop_front();
        if (mon_got !== mon_want) begin
          if (mismatches < 10)
            $display("mismatch: got k%0d w%h s%0d i%0d, want k%0d w%h s%0d i%0d",
                     mon_got.kind, mon_got.word, mon_got.status, mon_got.index,
                     mon_want.kind, mon_want.word, mon_want.status, mon_want.index);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned ph, base, style, pairs;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_table[i])
      offer({dir_table[i].fs, dir_table[i].rgb}, dir_table[i].typed,
            {cpd_pkg::KindStatus, 32'h0, dir_table[i].status, 7'h0});

    for (ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: program_regs(cpd_pkg::WhiteThresholdRst, cpd_pkg::BlackThresholdRst,
                        cpd_pkg::HueMarginRst);
        1: program_regs(8'd255, 8'd0, 8'd0);
        2: program_regs(8'd0, 8'd255, 8'd255);
        3: program_regs(8'($urandom_range(150, 240)), 8'($urandom_range(5, 60)),
                        8'($urandom_range(0, 40)));
        default: program_regs(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      base = live_items;
      while (live_items - base < phase_budget[ph]) begin
        calm = ($urandom_range(0, 3) == 0);
        style = $urandom_range(0, 9);
        if (style < 7) style = FrameGood;
        else if (style < 9) style = FrameBlack;
        else style = FrameBroken;
        pairs = 0;
        if (style == FrameGood)
          pairs = ($urandom_range(0, 7) == 0) ? $urandom_range(140, 400)
                                              : $urandom_range(0, 140);
        run_frame(style, pairs);
      end
    end
    calm = 1'b0;
    settle();

    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
sv/cpd_pkg.sv
sv/cpd_front.sv
sv/cpd_queue.sv
sv/cpd_back.sv
sv/color_pair_dibit_stream_decoder_unit.sv
sv/cpd_checker.sv
dv/color_pair_dibit_stream_decoder_unit_tb.sv
